// ===== hw/rtl/mlps_pkg.sv =====
// ----------------------------------------------------------------------------
// mlps_pkg - shared definitions for the multilook power summer
// Default sizes, configuration register map and register field widths.
// ----------------------------------------------------------------------------
package mlps_pkg;

  localparam int unsigned DEF_MAX_LINE_WIDTH = 4096;
  localparam int unsigned DEF_MAX_LOOKS      = 64;
  localparam int unsigned DEF_SAMPLE_BITS    = 16;

  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 13;
  localparam int unsigned LINE_WIDTH_W   = 13;
  localparam int unsigned LOOKS_REG_W    = 7;

  localparam int unsigned LINE_WIDTH_RST = 1024;
  localparam int unsigned LOOKS_RST      = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH   = 2'd0,
    CFG_LOOKS_ACROSS = 2'd1,
    CFG_LOOKS_DOWN   = 2'd2
  } cfg_reg_e;

endpackage

// ===== hw/rtl/multilook_power_sum.sv =====
// ----------------------------------------------------------------------------
// multilook_power_sum - SAR multilook power summer
// Sums sample power over looks_down lines per column, then over groups of
// looks_across columns on the last line of each block.
// ----------------------------------------------------------------------------
// A result passes through the stage 1 and output registers before m_axis.
// Throughput: one sample per cycle while m_axis is not back-pressured and the
// divider is idle; the column accumulator RAM does one read and one write per
// cycle with a bypass for back-to-back column hits. After reset and after every
// configuration write the bit-serial group-count divider runs with s_axis_tready low.
// Reset clears counters and handshake state; accumulator RAM is not cleared.
module multilook_power_sum #(
  parameter int unsigned MAX_LINE_WIDTH = mlps_pkg::DEF_MAX_LINE_WIDTH,
  parameter int unsigned MAX_LOOKS      = mlps_pkg::DEF_MAX_LOOKS,
  parameter int unsigned SAMPLE_BITS    = mlps_pkg::DEF_SAMPLE_BITS,
  localparam int unsigned COL_W  = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1,
  localparam int unsigned LG     = $clog2(MAX_LOOKS),
  localparam int unsigned POW_W  = 2 * SAMPLE_BITS,
  localparam int unsigned ACC_W  = POW_W + LG,
  localparam int unsigned SUM_W  = ACC_W + LG,
  localparam int unsigned IN_TW  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_TW = ((SUM_W + COL_W + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mlps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mlps_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // sample stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [IN_TW-1:0]                   s_axis_tdata,  // sample_re, sample_im
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [OUT_TW-1:0]                  m_axis_tdata,  // power_sum, output_column
  output logic                               m_axis_tlast   // last_in_line
);

  localparam int unsigned WW     = $clog2(MAX_LINE_WIDTH + 1);
  localparam int unsigned LW     = $clog2(MAX_LOOKS + 1);
  localparam int unsigned LINE_W = (MAX_LOOKS > 1) ? $clog2(MAX_LOOKS) : 1;
  localparam int unsigned STEP_W = $clog2(WW + 1);
  localparam int unsigned W_RST  = (mlps_pkg::LINE_WIDTH_RST > MAX_LINE_WIDTH) ?
                                   MAX_LINE_WIDTH : mlps_pkg::LINE_WIDTH_RST;
  localparam int unsigned L_RST  = (mlps_pkg::LOOKS_RST > MAX_LOOKS) ?
                                   MAX_LOOKS : mlps_pkg::LOOKS_RST;

  // ---------------------------------------------------------------- config
  logic [WW-1:0] w_q;
  logic [LW-1:0] la_q, ld_q;
  logic          cfg_fire;
  logic [mlps_pkg::LINE_WIDTH_W-1:0] cfg_w_raw;
  logic [mlps_pkg::LOOKS_REG_W-1:0]  cfg_l_raw;
  logic [WW-1:0] cfg_w_clamp;
  logic [LW-1:0] cfg_l_clamp;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign cfg_w_raw   = cfg_data_i[mlps_pkg::LINE_WIDTH_W-1:0];
  assign cfg_l_raw   = cfg_data_i[mlps_pkg::LOOKS_REG_W-1:0];

  always_comb begin
    if (cfg_w_raw == '0) begin
      cfg_w_clamp = WW'(1);
    end else if (int'(cfg_w_raw) > int'(MAX_LINE_WIDTH)) begin
      cfg_w_clamp = WW'(MAX_LINE_WIDTH);
    end else begin
      cfg_w_clamp = WW'(cfg_w_raw);
    end
    if (cfg_l_raw == '0) begin
      cfg_l_clamp = LW'(1);
    end else if (int'(cfg_l_raw) > int'(MAX_LOOKS)) begin
      cfg_l_clamp = LW'(MAX_LOOKS);
    end else begin
      cfg_l_clamp = LW'(cfg_l_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q  <= WW'(W_RST);
      la_q <= LW'(L_RST);
      ld_q <= LW'(L_RST);
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        mlps_pkg::CFG_LINE_WIDTH:   w_q  <= cfg_w_clamp;
        mlps_pkg::CFG_LOOKS_ACROSS: la_q <= cfg_l_clamp;
        mlps_pkg::CFG_LOOKS_DOWN:   ld_q <= cfg_l_clamp;
        default: ;
      endcase
    end
  end

  // ------------------------------------- groups = w / la, bit-serial divide
  logic              div_load_q;
  logic [STEP_W-1:0] step_q;
  logic [LW-1:0]     rem_q, rem_next;
  logic [WW-1:0]     quo_q, quo_next;
  logic [LW:0]       div_trial;
  logic              div_ge;
  logic [WW-1:0]     groups_q, limit_q;
  logic              div_busy;

  assign div_trial = {rem_q, quo_q[WW-1]};
  assign div_ge    = div_trial >= {1'b0, la_q};
  assign rem_next  = div_ge ? LW'(div_trial - {1'b0, la_q}) : div_trial[LW-1:0];
  assign quo_next  = {quo_q[WW-2:0], div_ge};
  assign div_busy  = div_load_q || (step_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_load_q <= 1'b1;
      step_q     <= '0;
    end else if (cfg_fire) begin
      div_load_q <= 1'b1;
    end else if (div_load_q) begin
      div_load_q <= 1'b0;
      step_q     <= STEP_W'(WW);
    end else if (step_q != '0) begin
      step_q     <= step_q - STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_load_q) begin
      rem_q <= '0;
      quo_q <= w_q;
    end else if (step_q != '0) begin
      rem_q <= rem_next;
      quo_q <= quo_next;
      if (step_q == STEP_W'(1)) begin
        groups_q <= quo_next;
        limit_q  <= w_q - WW'(rem_next);
      end
    end
  end

  // ------------------------------------------------ input stage, counters
  logic                   s1_valid_q, s1_fire, in_fire;
  logic [COL_W-1:0]       col_q;
  logic [LINE_W-1:0]      line_q;
  logic                   last_line, eol;
  logic signed [SAMPLE_BITS-1:0] in_re, in_im;
  logic [SAMPLE_BITS-1:0] mag_re, mag_im;
  logic [POW_W-1:0]       sq_re, sq_im;

  assign in_re     = s_axis_tdata[SAMPLE_BITS-1:0];
  assign in_im     = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign mag_re    = in_re[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_re) : SAMPLE_BITS'(in_re);
  assign mag_im    = in_im[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_im) : SAMPLE_BITS'(in_im);
  assign sq_re     = POW_W'(mag_re) * POW_W'(mag_re);
  assign sq_im     = POW_W'(mag_im) * POW_W'(mag_im);

  assign s_axis_tready = !div_busy && (!s1_valid_q || s1_fire);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign last_line     = (LW'(line_q) + LW'(1)) >= ld_q;
  assign eol           = (WW'(col_q) + WW'(1)) >= w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      line_q <= '0;
    end else if (in_fire) begin
      if (eol) begin
        col_q  <= '0;
        line_q <= last_line ? '0 : line_q + LINE_W'(1);
      end else begin
        col_q  <= col_q + COL_W'(1);
      end
    end
  end

  // stage 1 payload
  logic [POW_W-1:0] s1_power_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_first_q, s1_tally_q, s1_eol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_power_q <= sq_re + sq_im;
      s1_col_q   <= col_q;
      s1_first_q <= (line_q == '0);
      s1_tally_q <= last_line && (WW'(col_q) < limit_q);
      s1_eol_q   <= eol;
    end
  end

  // ----------------------------------------------- column accumulator RAM
  logic [ACC_W-1:0] acc_mem [MAX_LINE_WIDTH];
  logic [ACC_W-1:0] rd_q, fwd_val_q, acc_old, colsum;
  logic             fwd_q;

  assign acc_old = s1_first_q ? '0 : (fwd_q ? fwd_val_q : rd_q);
  assign colsum  = acc_old + ACC_W'(s1_power_q);

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      acc_mem[s1_col_q] <= colsum;
    end
    if (in_fire) begin
      rd_q <= acc_mem[col_q];
    end
  end

  // bypass when the column being read is written back in the same cycle
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fwd_q     <= s1_fire && (s1_col_q == col_q);
      fwd_val_q <= colsum;
    end
  end

  // -------------------------------------------------- group accumulation
  logic [SUM_W-1:0] gsum_q, gsum_inc;
  logic [LW-1:0]    fill_q, fill_inc;
  logic [COL_W-1:0] gi_q;
  logic             emit;

  assign gsum_inc = gsum_q + SUM_W'(colsum);
  assign fill_inc = fill_q + LW'(1);
  assign emit     = s1_tally_q && (fill_inc >= la_q);
  assign s1_fire  = s1_valid_q && (!emit || !m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gsum_q <= '0;
      fill_q <= '0;
      gi_q   <= '0;
    end else if (s1_fire) begin
      if (s1_eol_q) begin
        gsum_q <= '0;
        fill_q <= '0;
        gi_q   <= '0;
      end else if (emit) begin
        gsum_q <= '0;
        fill_q <= '0;
        gi_q   <= gi_q + COL_W'(1);
      end else if (s1_tally_q) begin
        gsum_q <= gsum_inc;
        fill_q <= fill_inc;
      end
    end
  end

  // ----------------------------------------------------- output register
  logic             out_valid_q, out_last_q;
  logic [SUM_W-1:0] out_sum_q;
  logic [COL_W-1:0] out_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && emit) begin
      out_sum_q  <= gsum_inc;
      out_col_q  <= gi_q;
      out_last_q <= (WW'(gi_q) + WW'(1)) >= groups_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TW'({out_col_q, out_sum_q});
  assign m_axis_tlast  = out_last_q;

endmodule
